FILE: src/ilse_pkg.sv
`default_nettype none

package ilse_pkg;

	// Field widths of the request and response transactions
	localparam int unsigned MODE_W = 3;
	localparam int unsigned POS_W  = 8;
	localparam int unsigned DIN_W  = 32;
	localparam int unsigned RD_W   = 32;

	// Signed working width of an element index; covers counts up to 2**15 - 1
	localparam int unsigned IDX_W = 16;

	typedef logic signed [IDX_W-1:0] idx_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_PUSH   = 3'd0,
		MODE_READ   = 3'd1,
		MODE_WRITE  = 3'd2,
		MODE_INSERT = 3'd3,
		MODE_DELETE = 3'd4,
		MODE_PEEK   = 3'd5,
		MODE_POP    = 3'd6,
		MODE_CLEAR  = 3'd7
	} mode_t;

	// Command that every cell of the chain carries out
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_SHIFT_UP,
		CELL_SHIFT_DOWN
	} cell_op_t;

	typedef struct packed {
		cell_op_t   op;
		logic [IDX_W-1:0] tgt;
		logic [IDX_W-1:0] rd_tgt;
	} cell_ctl_t;

endpackage

`default_nettype wire

FILE: src/ilse_in_if.sv
`default_nettype none

interface ilse_in_if;
	logic                                valid;
	logic                                ready;
	logic [ilse_pkg::MODE_W-1:0]         mode;
	logic signed [ilse_pkg::POS_W-1:0]   position;
	logic [ilse_pkg::DIN_W-1:0]          data_in;

	modport source (output valid, output mode, output position, output data_in, input ready);
	modport sink   (input valid, input mode, input position, input data_in, output ready);
endinterface

`default_nettype wire

FILE: src/ilse_out_if.sv
`default_nettype none

interface ilse_out_if #(
	parameter int unsigned CNT_W = 7
);
	logic                        valid;
	logic                        ready;
	logic                        status;
	logic [ilse_pkg::RD_W-1:0]   read_data;
	logic [CNT_W-1:0]            item_count;

	modport source (output valid, output status, output read_data, output item_count, input ready);
	modport sink   (input valid, input status, input read_data, input item_count, output ready);
endinterface

`default_nettype wire

FILE: src/indexed_list_stack_engine.sv
// Bounded ordered list with stack operations, built as a chain of storage cells.
// Request channel (req) carries mode, signed position and data_in; the response
// channel (rsp) returns status, read_data and item_count, one response per request.
// Negative positions count from the end: -1 addresses the slot just past the top.
// Insert moves every entry from the index upward by one cell; delete moves every
// entry above the index down by one. Each cell takes from its lower or upper
// neighbor. A request accepted at a clock edge has its response registered at
// that edge. Throughput: one request per cycle while rsp.ready is high. The whole
// operation, shift included, ends in the acceptance cycle; all cells move in parallel.
// The response sits in an output register; req.ready stays high while that
// register is empty or being drained, so a stalled receiver holds one response and
// blocks further requests until it is taken.
// Reset clears the item count and the output valid; cell contents are left as is
// and are only read below the count, so no clearing pass is needed.
`default_nettype none

module indexed_list_stack_engine #(
	parameter int unsigned CAPACITY   = 64,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  wire        clk,
	input  wire        arst_n,
	ilse_in_if.sink    req,
	ilse_out_if.source rsp
);
	import ilse_pkg::*;

	localparam int unsigned      CNT_W   = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      count_nxt;
	logic                  acc;
	mode_t                 mode;
	idx_t                  cnt_s;
	idx_t                  pos_s;
	idx_t                  eff;
	logic                  in_rng;
	logic                  ins_rng;
	logic                  full;
	logic                  err;
	logic                  rd_en;
	cell_ctl_t             ctl;
	logic [DATA_WIDTH-1:0] din;
	logic [DATA_WIDTH-1:0] rd_sel;
	logic [RD_W-1:0]       rd_val;

	logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
	logic [DATA_WIDTH-1:0] cell_rd   [CAPACITY];

	logic                  valid_q;
	logic                  status_q;
	logic [RD_W-1:0]       rdata_q;
	logic [CNT_W-1:0]      cnt_out_q;

	assign req.ready = !valid_q || rsp.ready;
	assign acc       = req.valid && req.ready;
	assign mode      = mode_t'(req.mode);
	assign din       = DATA_WIDTH'(req.data_in);

	// Resolve the effective index and range checks
	always_comb begin
		cnt_s   = idx_t'({1'b0, count_q});
		pos_s   = idx_t'(req.position);
		eff     = (pos_s < 0) ? (cnt_s + pos_s + idx_t'(1)) : pos_s;
		in_rng  = (eff >= 0) && (eff < cnt_s);
		ins_rng = (eff >= 0) && (eff <= cnt_s);
		full    = (count_q == CAP_CNT);
	end

	// Decode the mode into a cell command, error and new count
	always_comb begin
		err        = 1'b0;
		rd_en      = 1'b0;
		count_nxt  = count_q;
		ctl.op     = CELL_HOLD;
		ctl.tgt    = IDX_W'(eff);
		ctl.rd_tgt = IDX_W'(eff);
		case (mode)
			MODE_PUSH: begin
				err     = full;
				ctl.tgt = IDX_W'(count_q);
				if (!full) begin
					ctl.op    = CELL_LOAD;
					count_nxt = count_q + CNT_W'(1);
				end
			end
			MODE_READ: begin
				err   = !in_rng;
				rd_en = 1'b1;
			end
			MODE_WRITE: begin
				err = !in_rng;
				if (in_rng) ctl.op = CELL_LOAD;
			end
			MODE_INSERT: begin
				err = !ins_rng || full;
				if (ins_rng && !full) begin
					ctl.op    = CELL_SHIFT_UP;
					count_nxt = count_q + CNT_W'(1);
				end
			end
			MODE_DELETE: begin
				err = !in_rng;
				if (in_rng) begin
					ctl.op    = CELL_SHIFT_DOWN;
					count_nxt = count_q - CNT_W'(1);
				end
			end
			MODE_PEEK: begin
				err        = (count_q == '0);
				rd_en      = 1'b1;
				ctl.rd_tgt = IDX_W'(count_q - CNT_W'(1));
			end
			MODE_POP: begin
				if (count_q != '0) count_nxt = count_q - CNT_W'(1);
				err        = (count_nxt == '0);
				rd_en      = 1'b1;
				ctl.rd_tgt = IDX_W'(count_nxt - CNT_W'(1));
			end
			MODE_CLEAR: begin
				count_nxt = '0;
			end
			default: begin
			end
		endcase
		if (!acc) ctl.op = CELL_HOLD;
	end

	// Chain of storage cells
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [DATA_WIDTH-1:0] prev_d;
		logic [DATA_WIDTH-1:0] next_d;
		if (g == 0) begin : g_first
			assign prev_d = '0;
		end else begin : g_mid_lo
			assign prev_d = cell_data[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign next_d = '0;
		end else begin : g_mid_hi
			assign next_d = cell_data[g+1];
		end
		ilse_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.POS        (g)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.din       (din),
			.prev_data (prev_d),
			.next_data (next_d),
			.data      (cell_data[g]),
			.rd_data   (cell_rd[g])
		);
	end

	// Merge the addressed cell onto the read bus
	always_comb begin
		rd_sel = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_sel = rd_sel | cell_rd[i];
		end
		rd_val = (rd_en && !err) ? RD_W'(rd_sel) : '0;
	end

	// Advance the item count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (acc) begin
			count_q <= count_nxt;
		end
	end

	// Hold the response until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (acc) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			status_q  <= err;
			rdata_q   <= rd_val;
			cnt_out_q <= count_nxt;
		end
	end

	assign rsp.valid      = valid_q;
	assign rsp.status     = status_q;
	assign rsp.read_data  = rdata_q;
	assign rsp.item_count = cnt_out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_CNT)
		else $error("item count above capacity");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		acc && (mode == MODE_CLEAR) |=> (count_q == '0))
		else $error("clear did not empty the list");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		acc && (mode == MODE_PUSH) && !full |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("push did not grow the list");

	a_rsp_count: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> (rsp.item_count == count_q) && rsp.valid)
		else $error("response count disagrees with stored count");

endmodule

`default_nettype wire

FILE: src/ilse_cell.sv
`default_nettype none

module ilse_cell #(
	parameter int unsigned DATA_WIDTH = 32,
	parameter int unsigned POS        = 0
) (
	input  wire                         clk,
	input  wire ilse_pkg::cell_ctl_t    ctl,
	input  wire  [DATA_WIDTH-1:0]       din,
	input  wire  [DATA_WIDTH-1:0]       prev_data,
	input  wire  [DATA_WIDTH-1:0]       next_data,
	output logic [DATA_WIDTH-1:0]       data,
	output logic [DATA_WIDTH-1:0]       rd_data
);
	import ilse_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(POS);

	logic [DATA_WIDTH-1:0] data_q;
	logic                  at_tgt;
	logic                  above_tgt;

	assign at_tgt    = (ctl.tgt == MY_IDX);
	assign above_tgt = (MY_IDX > ctl.tgt);

	// Load, take from the lower neighbor on insert, or from the upper one on delete
	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_LOAD: begin
				if (at_tgt) data_q <= din;
			end
			CELL_SHIFT_UP: begin
				if (at_tgt)         data_q <= din;
				else if (above_tgt) data_q <= prev_data;
			end
			CELL_SHIFT_DOWN: begin
				if (at_tgt || above_tgt) data_q <= next_data;
			end
			default: begin
			end
		endcase
	end

	assign data = data_q;

	// Drive the shared read bus only when addressed
	assign rd_data = (ctl.rd_tgt == MY_IDX) ? data_q : '0;

endmodule

`default_nettype wire

FILE: dv/tb_indexed_list_stack_engine.sv
`timescale 1ns / 1ps

module tb_indexed_list_stack_engine;
	import ilse_pkg::*;

	localparam int unsigned LIST_DEPTH = 64;
	localparam int unsigned COUNT_W    = 7;
	localparam int          RANDOM_OPS = 1830;
	localparam int          CALM_TAIL  = 120;

	typedef struct {
		mode_t                   mode;
		logic signed [POS_W-1:0] position;
		logic [DIN_W-1:0]        data_in;
	} list_op_t;

	typedef struct {
		logic               status;
		logic [RD_W-1:0]    read_data;
		logic [COUNT_W-1:0] item_count;
	} list_result_t;

	logic clk;
	logic arst_n = 1'b0;

	// Request and response channels, driven from known values at time zero
	ilse_in_if                    req_if ();
	ilse_out_if #(.CNT_W(COUNT_W)) rsp_if ();

	logic                    send_valid    = 1'b0;
	mode_t                   send_mode     = MODE_PUSH;
	logic signed [POS_W-1:0] send_position = '0;
	logic [DIN_W-1:0]        send_data     = '0;
	logic                    take_ready    = 1'b0;

	assign req_if.valid    = send_valid;
	assign req_if.mode     = send_mode;
	assign req_if.position = send_position;
	assign req_if.data_in  = send_data;
	assign rsp_if.ready    = take_ready;

	indexed_list_stack_engine dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	list_op_t     pending_ops[$];
	list_result_t awaited_results[$];

	// Shadow of the list as the block should hold it
	logic [DIN_W-1:0] list_mem[LIST_DEPTH];
	int               list_count = 0;

	// Count seen by the stimulus generator, used to aim positions
	int gen_count = 0;

	int fault_count   = 0;
	int checked_count = 0;
	int error_results = 0;
	int full_results  = 0;
	int send_gap      = 0;
	int take_hold     = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("== FAIL ==");
		$finish;
	end

	// Resolve a signed position against the current count
	function automatic int resolve_index(logic signed [POS_W-1:0] pos, int cnt);
		int p;
		p = pos;
		return (p < 0) ? cnt + p + 1 : p;
	endfunction

	// Count after one operation at a resolved index
	function automatic int count_after(mode_t mode, int idx, int cnt);
		case (mode)
			MODE_PUSH:   return (cnt < LIST_DEPTH) ? cnt + 1 : cnt;
			MODE_INSERT: return (idx >= 0 && idx <= cnt && cnt < LIST_DEPTH) ? cnt + 1 : cnt;
			MODE_DELETE: return (idx >= 0 && idx < cnt) ? cnt - 1 : cnt;
			MODE_POP:    return (cnt > 0) ? cnt - 1 : cnt;
			MODE_CLEAR:  return 0;
			default:     return cnt;
		endcase
	endfunction

	// Apply one operation to the shadow list and queue its result
	task automatic model_list_op(list_op_t op);
		int           idx;
		int           nxt;
		list_result_t res;
		idx = resolve_index(op.position, list_count);
		nxt = count_after(op.mode, idx, list_count);
		res.status     = 1'b0;
		res.read_data  = '0;
		res.item_count = COUNT_W'(nxt);
		case (op.mode)
			MODE_PUSH: begin
				if (list_count >= LIST_DEPTH)
					res.status = 1'b1;
				else
					list_mem[list_count] = op.data_in;
			end
			MODE_READ: begin
				if (idx < 0 || idx >= list_count)
					res.status = 1'b1;
				else
					res.read_data = list_mem[idx];
			end
			MODE_WRITE: begin
				if (idx < 0 || idx >= list_count)
					res.status = 1'b1;
				else
					list_mem[idx] = op.data_in;
			end
			MODE_INSERT: begin
				if (idx < 0 || idx > list_count || list_count >= LIST_DEPTH) begin
					res.status = 1'b1;
				end else begin
					for (int i = list_count; i > idx; i--)
						list_mem[i] = list_mem[i-1];
					list_mem[idx] = op.data_in;
				end
			end
			MODE_DELETE: begin
				if (idx < 0 || idx >= list_count) begin
					res.status = 1'b1;
				end else begin
					for (int i = idx; i + 1 < list_count; i++)
						list_mem[i] = list_mem[i+1];
				end
			end
			MODE_PEEK: begin
				if (list_count == 0)
					res.status = 1'b1;
				else
					res.read_data = list_mem[list_count-1];
			end
			MODE_POP: begin
				// drop happens even when the list ends up empty
				if (nxt == 0)
					res.status = 1'b1;
				else
					res.read_data = list_mem[nxt-1];
			end
			default: begin
			end
		endcase
		list_count = nxt;
		awaited_results.push_back(res);
	endtask

	task automatic queue_op(mode_t mode, int pos, logic [DIN_W-1:0] data);
		list_op_t op;
		op.mode     = mode;
		op.position = POS_W'(pos);
		op.data_in  = data;
		gen_count   = count_after(mode, resolve_index(op.position, gen_count), gen_count);
		pending_ops.push_back(op);
	endtask

	// Pick an operation; bias 0 grows the list, 1 shrinks it, 2 mixes evenly
	function automatic mode_t pick_mode(int bias);
		int r;
		r = $urandom_range(0, 99);
		case (bias)
			0: begin
				if (r < 35) return MODE_PUSH;
				if (r < 60) return MODE_INSERT;
				if (r < 70) return MODE_READ;
				if (r < 80) return MODE_WRITE;
				if (r < 87) return MODE_DELETE;
				if (r < 93) return MODE_PEEK;
				if (r < 99) return MODE_POP;
				return MODE_CLEAR;
			end
			1: begin
				if (r < 30) return MODE_POP;
				if (r < 60) return MODE_DELETE;
				if (r < 70) return MODE_PUSH;
				if (r < 75) return MODE_INSERT;
				if (r < 83) return MODE_READ;
				if (r < 91) return MODE_WRITE;
				if (r < 99) return MODE_PEEK;
				return MODE_CLEAR;
			end
			default: begin
				if (r < 98) return mode_t'(r % 7);
				return MODE_CLEAR;
			end
		endcase
	endfunction

	// Aim most positions inside the list, from either end; the rest anywhere
	function automatic int pick_position();
		int r;
		r = $urandom_range(0, 3);
		if (r < 2)
			return $urandom_range(0, gen_count);
		if (r == 2)
			return -$urandom_range(1, gen_count + 1);
		return $urandom_range(0, 129) - 65;
	endfunction

	// Sender: hold a transaction until taken, idle in bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			send_valid <= 1'b0;
			send_gap   <= 0;
		end else if (!send_valid || req_if.ready) begin
			if (send_gap != 0) begin
				send_gap   <= send_gap - 1;
				send_valid <= 1'b0;
			end else if (pending_ops.size() > CALM_TAIL
			             && (pending_ops.size() / 100) % 3 != 0
			             && $urandom_range(0, 9) == 0) begin
				send_gap   <= $urandom_range(0, 14);
				send_valid <= 1'b0;
			end else if (pending_ops.size() != 0) begin
				list_op_t op;
				op = pending_ops.pop_front();
				send_mode     <= op.mode;
				send_position <= op.position;
				send_data     <= op.data_in;
				send_valid    <= 1'b1;
			end else begin
				send_valid <= 1'b0;
			end
		end
	end

	// Receiver: stall in bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			take_ready <= 1'b0;
			take_hold  <= 0;
		end else if (take_hold != 0) begin
			take_hold  <= take_hold - 1;
			take_ready <= (take_hold == 1);
		end else if (pending_ops.size() > CALM_TAIL
		             && ((pending_ops.size() + 50) / 100) % 3 != 0
		             && $urandom_range(0, 7) == 0) begin
			take_hold  <= $urandom_range(1, 15);
			take_ready <= 1'b0;
		end else begin
			take_ready <= 1'b1;
		end
	end

	// Monitor: check responses against the oldest expectation, then model requests
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready) begin
				if (awaited_results.size() == 0) begin
					$display("%0t: response with none expected: status=%0b data=%h count=%0d",
					         $time, rsp_if.status, rsp_if.read_data, rsp_if.item_count);
					fault_count++;
				end else begin
					list_result_t exp_res;
					exp_res = awaited_results.pop_front();
					checked_count++;
					if (exp_res.status) error_results++;
					if (exp_res.item_count == LIST_DEPTH) full_results++;
					if (rsp_if.status !== exp_res.status) begin
						$display("%0t: status mismatch: expected %0b, actual %0b",
						         $time, exp_res.status, rsp_if.status);
						fault_count++;
					end
					if (rsp_if.read_data !== exp_res.read_data) begin
						$display("%0t: read_data mismatch: expected %h, actual %h",
						         $time, exp_res.read_data, rsp_if.read_data);
						fault_count++;
					end
					if (rsp_if.item_count !== exp_res.item_count) begin
						$display("%0t: item_count mismatch: expected %0d, actual %0d",
						         $time, exp_res.item_count, rsp_if.item_count);
						fault_count++;
					end
				end
			end
			if (req_if.valid && req_if.ready) begin
				list_op_t op;
				op.mode     = mode_t'(req_if.mode);
				op.position = req_if.position;
				op.data_in  = req_if.data_in;
				model_list_op(op);
			end
		end
	end

	initial begin
		int bias;
		int seg_len;
		int made;

		// Directed: empty-list errors, read at count, range edges, shifts, pop to empty
		queue_op(MODE_PEEK,    5,   32'hFFFF_FFFF);
		queue_op(MODE_POP,     -1,  32'hFFFF_FFFF);
		queue_op(MODE_READ,    0,   32'h0);
		queue_op(MODE_DELETE,  -1,  32'h0);
		queue_op(MODE_INSERT,  -1,  32'hFFFF_FFFF);
		queue_op(MODE_PUSH,    0,   32'h0000_0000);
		queue_op(MODE_PUSH,    -65, 32'hA5A5_A5A5);
		queue_op(MODE_READ,    -1,  32'h0);
		queue_op(MODE_READ,    -2,  32'h0);
		queue_op(MODE_READ,    0,   32'h0);
		queue_op(MODE_WRITE,   -65, 32'h5A5A_5A5A);
		queue_op(MODE_WRITE,   64,  32'h5A5A_5A5A);
		queue_op(MODE_WRITE,   1,   32'h1234_5678);
		queue_op(MODE_INSERT,  1,   32'hDEAD_BEEF);
		queue_op(MODE_INSERT,  5,   32'hCAFE_F00D);
		queue_op(MODE_DELETE,  -1,  32'h0);
		queue_op(MODE_DELETE,  0,   32'h0);
		queue_op(MODE_DELETE,  -2,  32'h0);
		queue_op(MODE_PEEK,    0,   32'h0);
		queue_op(MODE_POP,     0,   32'h0);
		queue_op(MODE_POP,     0,   32'h0);
		queue_op(MODE_PUSH,    0,   32'h8000_0001);
		queue_op(MODE_CLEAR,   -128, 32'hFFFF_FFFF);

		// Random: segments that grow, shrink or churn the list
		made = 0;
		while (made < RANDOM_OPS) begin
			bias    = (made == 0) ? 0 : $urandom_range(0, 2);
			seg_len = $urandom_range(30, 120);
			for (int i = 0; i < seg_len && made < RANDOM_OPS; i++) begin
				queue_op(pick_mode(bias), pick_position(), $urandom());
				made++;
			end
		end

		// Hold reset, then let the channels run
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_ops.size() != 0 || send_valid || awaited_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("Checked %0d responses: %0d flagged errors, %0d at full capacity.",
		         checked_count, error_results, full_results);
		$display("Covered push, read, write, insert, delete, peek, pop and clear with stalls.");
		if (fault_count == 0 && awaited_results.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
